@@ sv/i2cbb_pkg.sv @@
// Shared types, command and pin-operation codes for the bit-banged I2C master.
// Holds the per-command operation sequences as constant tables and their lookup.
// No dependencies; the core, sequencer and configuration files use it by scoped names.
package i2cbb_pkg;

    // Commands carried by an input transaction.
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ      = 3'd4,
        CMD_NACK      = 3'd5,
        CMD_BUS_RESET = 3'd6,
        CMD_DEV_READ  = 3'd7
    } t_cmd;

    // One pin operation per bus tick.
    typedef enum logic [3:0] {
        OP_END     = 4'd0,
        OP_SCL0    = 4'd1,
        OP_SCL1    = 4'd2,
        OP_SDA0    = 4'd3,
        OP_SDA1    = 4'd4,
        OP_SDABIT  = 4'd5,
        OP_SAMPLE  = 4'd6,
        OP_RELEASE = 4'd7,
        OP_DRIVE   = 4'd8,
        OP_WAITACK = 4'd9
    } t_op;

    localparam int unsigned PHASE_W = 6;
    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned RESET_CLOCKS = 9;

    // Configuration register map.
    localparam logic [1:0] REG_DEV_ADDR = 2'd0;

    typedef t_op t_seq [0:(1 << PHASE_W) - 1];

    // Input item of one tick.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       sda_sample;
    } t_in_item;

    // Result item of one tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } t_res;

    // Pin state: clock level, data latch, data released.
    typedef struct packed {
        logic scl;
        logic sda;
        logic rel;
    } t_pins;

    // Builds the operation sequence of one command at elaboration time.
    function automatic t_seq build_seq(input t_cmd cmd);
        t_seq           s;
        logic [PHASE_W-1:0] n;
        n = '0;
        for (int i = 0; i < (1 << PHASE_W); i++) begin
            s[i] = OP_END;
        end
        // Start condition.
        if (cmd == CMD_START || cmd == CMD_BUS_RESET || cmd == CMD_DEV_READ) begin
            s[n] = OP_SDA1; n = n + 1'b1;
            s[n] = OP_SCL1; n = n + 1'b1;
            s[n] = OP_SDA0; n = n + 1'b1;
            s[n] = OP_SCL0; n = n + 1'b1;
        end
        // Byte write, MSB first.
        if (cmd == CMD_WRITE || cmd == CMD_DEV_READ) begin
            s[n] = OP_SCL0; n = n + 1'b1;
            for (int k = 0; k < BITS_PER_BYTE; k++) begin
                s[n] = OP_SDABIT; n = n + 1'b1;
                s[n] = OP_SCL1;   n = n + 1'b1;
                s[n] = OP_SCL0;   n = n + 1'b1;
            end
            s[n] = OP_SDA0; n = n + 1'b1;
        end
        // Wait for the slave acknowledge.
        if (cmd == CMD_DEV_READ) begin
            s[n] = OP_RELEASE; n = n + 1'b1;
            s[n] = OP_SCL1;    n = n + 1'b1;
            s[n] = OP_WAITACK; n = n + 1'b1;
            s[n] = OP_SCL0;    n = n + 1'b1;
            s[n] = OP_DRIVE;   n = n + 1'b1;
        end
        // Byte read, sampled on the rising clock.
        if (cmd == CMD_READ || cmd == CMD_DEV_READ) begin
            s[n] = OP_SDA1;    n = n + 1'b1;
            s[n] = OP_RELEASE; n = n + 1'b1;
            for (int k = 0; k < BITS_PER_BYTE; k++) begin
                s[n] = OP_SAMPLE; n = n + 1'b1;
                s[n] = OP_SCL0;   n = n + 1'b1;
            end
            s[n] = OP_DRIVE; n = n + 1'b1;
        end
        // Not-acknowledge.
        if (cmd == CMD_NACK || cmd == CMD_DEV_READ) begin
            s[n] = OP_SCL0; n = n + 1'b1;
            s[n] = OP_SDA1; n = n + 1'b1;
            s[n] = OP_SCL1; n = n + 1'b1;
            s[n] = OP_SCL0; n = n + 1'b1;
        end
        // Free clock pulses on SCL for the bus reset, RESET_CLOCKS in all.
        if (cmd == CMD_BUS_RESET) begin
            for (int k = 0; k < RESET_CLOCKS; k++) begin
                s[n] = OP_SDA1; n = n + 1'b1;
                s[n] = OP_SCL1; n = n + 1'b1;
                s[n] = OP_SCL0; n = n + 1'b1;
            end
        end
        // Stop condition.
        if (cmd == CMD_STOP || cmd == CMD_BUS_RESET || cmd == CMD_DEV_READ) begin
            s[n] = OP_SDA0; n = n + 1'b1;
            s[n] = OP_SCL1; n = n + 1'b1;
            s[n] = OP_SDA1; n = n + 1'b1;
            s[n] = OP_SCL0; n = n + 1'b1;
        end
        return s;
    endfunction

    localparam t_seq SEQ_START     = build_seq(CMD_START);
    localparam t_seq SEQ_STOP      = build_seq(CMD_STOP);
    localparam t_seq SEQ_WRITE     = build_seq(CMD_WRITE);
    localparam t_seq SEQ_READ      = build_seq(CMD_READ);
    localparam t_seq SEQ_NACK      = build_seq(CMD_NACK);
    localparam t_seq SEQ_BUS_RESET = build_seq(CMD_BUS_RESET);
    localparam t_seq SEQ_DEV_READ  = build_seq(CMD_DEV_READ);

    // Operation of a command at a given phase.
    function automatic t_op seq_op(input t_cmd cmd, input logic [PHASE_W-1:0] phase);
        t_op op;
        case (cmd)
            CMD_START:     op = SEQ_START[phase];
            CMD_STOP:      op = SEQ_STOP[phase];
            CMD_WRITE:     op = SEQ_WRITE[phase];
            CMD_READ:      op = SEQ_READ[phase];
            CMD_NACK:      op = SEQ_NACK[phase];
            CMD_BUS_RESET: op = SEQ_BUS_RESET[phase];
            CMD_DEV_READ:  op = SEQ_DEV_READ[phase];
            default:       op = OP_END;
        endcase
        return op;
    endfunction

endpackage

@@ sv/i2cbb_in_if.sv @@
// Input channel of the I2C master: one tick command per transaction.
// Standalone interface, no dependencies.
interface i2cbb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_sample;

    modport source (output valid, output cmd, output tx_byte, output sda_sample,
                    input ready);
    modport sink (input valid, input cmd, input tx_byte, input sda_sample,
                  output ready);
endinterface

@@ sv/i2cbb_out_if.sv @@
// Result channel of the I2C master: pin levels and status per tick.
// Standalone interface, no dependencies.
interface i2cbb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;

    modport source (output valid, output scl_level, output sda_drive,
                    output sda_released, output busy_res, output done_res,
                    output rx_byte, input ready);
    modport sink (input valid, input scl_level, input sda_drive,
                  input sda_released, input busy_res, input done_res,
                  input rx_byte, output ready);
endinterface

@@ sv/i2c_bitbang_master_sequencer_core.sv @@
// Bit-banged I2C master: one bus tick per input transaction, one result per tick.
// An accepted tick waits in the input register and is stepped into the result register when
// that register is free or being emptied; the result is offered from there. One tick per cycle
// while the result channel is not stalled. Synchronous active-low reset
// returns SCL and SDA high and driven, idle, address register zero.
// Uses i2cbb_pkg, i2cbb_in_if, i2cbb_out_if, i2cbb_seq and i2cbb_cfg.
module i2c_bitbang_master_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbb_in_if.sink    i_in,
    i2cbb_out_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_in_valid;
    i2cbb_pkg::t_in_item r_in;
    logic                r_out_valid;
    i2cbb_pkg::t_res     r_out;
    i2cbb_pkg::t_res     step_res;
    logic [7:0]          dev_addr;
    logic                step;
    logic                in_ready;

    // A tick steps when the result register is free or being emptied.
    assign step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || step;
    assign i_in.ready = in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= '{cmd: i_in.cmd, tx_byte: i_in.tx_byte, sda_sample: i_in.sda_sample};
        end
    end

    i2cbb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_dev_addr (dev_addr)
    );

    i2cbb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_dev_addr (dev_addr),
        .o_res      (step_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.scl_level    = r_out.scl_level;
    assign o_res.sda_drive    = r_out.sda_drive;
    assign o_res.sda_released = r_out.sda_released;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.done_res     = r_out.done_res;
    assign o_res.rx_byte      = r_out.rx_byte;

endmodule

@@ sv/i2cbb_seq.sv @@
// Sequencer state and per-tick step logic of the bit-banged I2C master.
// Uses i2cbb_pkg for commands, pin operations and the sequence tables.
module i2cbb_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cbb_pkg::t_in_item i_item,
    input  logic [7:0]          i_dev_addr,
    output i2cbb_pkg::t_res     o_res
);

    i2cbb_pkg::t_cmd                  r_active, n_active;
    logic [i2cbb_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic [3:0]                       r_bc, n_bc;
    logic [7:0]                       r_sr, n_sr;
    logic [7:0]                       r_rx, n_rx;
    i2cbb_pkg::t_pins                 r_pins, n_pins;
    i2cbb_pkg::t_op                   op;
    i2cbb_pkg::t_op                   op_next;
    logic                             launch;
    logic                             v_busy;
    logic                             v_done;

    // One tick: take a new command when idle, then run one pin operation.
    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        n_bc     = r_bc;
        n_sr     = r_sr;
        n_rx     = r_rx;
        n_pins   = r_pins;
        op       = i2cbb_pkg::OP_END;
        op_next  = i2cbb_pkg::OP_END;
        v_busy   = 1'b0;
        v_done   = 1'b0;
        launch   = (r_active == i2cbb_pkg::CMD_TICK) &&
                   (i_item.cmd != i2cbb_pkg::CMD_TICK);

        if (launch) begin
            n_active = i2cbb_pkg::t_cmd'(i_item.cmd);
            n_phase  = '0;
            n_bc     = '0;
            if (i_item.cmd == i2cbb_pkg::CMD_WRITE) begin
                n_sr = i_item.tx_byte;
            end else if (i_item.cmd == i2cbb_pkg::CMD_DEV_READ) begin
                n_sr = i_dev_addr | 8'h01;
            end else begin
                n_sr = '0;
            end
        end

        if (n_active != i2cbb_pkg::CMD_TICK) begin
            op = i2cbb_pkg::seq_op(n_active, n_phase);
            case (op)
                i2cbb_pkg::OP_SCL0: n_pins.scl = 1'b0;
                i2cbb_pkg::OP_SCL1: n_pins.scl = 1'b1;
                i2cbb_pkg::OP_SDA0: n_pins.sda = 1'b0;
                i2cbb_pkg::OP_SDA1: n_pins.sda = 1'b1;
                i2cbb_pkg::OP_SDABIT: begin
                    n_pins.sda = n_sr[7];
                    n_sr       = {n_sr[6:0], 1'b0};
                    n_bc       = n_bc + 4'd1;
                end
                i2cbb_pkg::OP_SAMPLE: begin
                    n_pins.scl = 1'b1;
                    n_sr       = {n_sr[6:0], i_item.sda_sample};
                    n_bc       = n_bc + 4'd1;
                end
                i2cbb_pkg::OP_RELEASE: begin
                    n_pins.rel = 1'b1;
                    n_bc       = '0;
                end
                i2cbb_pkg::OP_DRIVE: begin
                    n_pins.rel = 1'b0;
                    if (n_bc == 4'(i2cbb_pkg::BITS_PER_BYTE)) begin
                        n_rx = n_sr;
                    end
                    n_bc = '0;
                end
                default: begin
                end
            endcase

            // The acknowledge wait repeats while SDA reads high.
            if (!(op == i2cbb_pkg::OP_WAITACK && i_item.sda_sample)) begin
                n_phase = n_phase + 1'b1;
                op_next = i2cbb_pkg::seq_op(n_active, n_phase);
                if (op_next == i2cbb_pkg::OP_END) begin
                    v_done   = 1'b1;
                    n_active = i2cbb_pkg::CMD_TICK;
                    n_phase  = '0;
                    n_bc     = '0;
                end
            end
            v_busy = (n_active != i2cbb_pkg::CMD_TICK);
        end
    end

    // State advances only when the tick is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= i2cbb_pkg::CMD_TICK;
            r_phase  <= '0;
            r_bc     <= '0;
            r_sr     <= '0;
            r_rx     <= '0;
            r_pins   <= '{scl: 1'b1, sda: 1'b1, rel: 1'b0};
        end else if (i_step) begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_bc     <= n_bc;
            r_sr     <= n_sr;
            r_rx     <= n_rx;
            r_pins   <= n_pins;
        end
    end

    // Result of this tick.
    always_comb begin
        o_res.scl_level    = n_pins.scl;
        o_res.sda_drive    = n_pins.sda;
        o_res.sda_released = n_pins.rel;
        o_res.busy_res     = v_busy;
        o_res.done_res     = v_done;
        o_res.rx_byte      = n_rx;
    end

`ifndef ASSERT_OFF
    // An idle sequencer holds no leftover phase or bit count.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == i2cbb_pkg::CMD_TICK |-> r_phase == '0 && r_bc == '0)
        else $error("idle sequencer with nonzero phase or bit count");

    // The bit counter never passes one byte.
    a_bc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= 4'(i2cbb_pkg::BITS_PER_BYTE))
        else $error("bit counter beyond one byte");

    // A released data line is only seen while a read sequence runs.
    a_rel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins.rel |-> r_active == i2cbb_pkg::CMD_READ ||
                       r_active == i2cbb_pkg::CMD_DEV_READ)
        else $error("data line released outside a read");

    // Without a step the sequencer state holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_active) && $stable(r_phase) && $stable(r_pins))
        else $error("sequencer state moved without a step");

    // A sequence that reports done on a step leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_active == i2cbb_pkg::CMD_TICK)
        else $error("sequencer still active after done");
`endif

endmodule

@@ sv/i2cbb_top_dummy.sv @@
// Holding register for the device address byte with its APB-style access.
// Uses i2cbb_pkg for the register map.
module i2cbb_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_dev_addr
);

    logic [7:0] r_dev_addr;
    logic       wr_en;

    // Write strobe on the access phase.
    assign wr_en  = psel && penable && pwrite && (paddr == i2cbb_pkg::REG_DEV_ADDR);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= '0;
        end else if (wr_en) begin
            r_dev_addr <= pwdata[7:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        if (paddr == i2cbb_pkg::REG_DEV_ADDR) begin
            prdata = {24'd0, r_dev_addr};
        end else begin
            prdata = '0;
        end
    end

    assign o_dev_addr = r_dev_addr;

endmodule
